// ===== rtl/core/klt_pkg.sv =====
package klt_pkg;

  localparam int LIST_SLOTS = 10;
  localparam int SLOT_AW    = $clog2(LIST_SLOTS);
  localparam int MAX_KEYS   = 16;
  localparam int KEY_W      = 4;
  localparam int TICK_W     = 17;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // Key state codes as carried in new_state.
  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_PRESSED  = 2'd1;
  localparam logic [1:0] ST_HOLD     = 2'd2;
  localparam logic [1:0] ST_RELEASED = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_HOLD     = 2'd1;
  localparam logic [1:0] REG_KEYS     = 2'd2;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [1:0]       kstate;
    logic             changed;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_CLEAR,
    FSM_SEARCH,
    FSM_ADVANCE,
    FSM_SUMMARY,
    FSM_REPORT
  } fsm_t;

endpackage

// ===== rtl/core/klt_ram.sv =====
module klt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/key_list_debounce_hold_tracker_core.sv =====
// Multi-key tracker for up to sixteen active-low key lines. Every accepted
// input transfer is one millisecond tick. Once more ticks than debounce_ticks
// have passed since the previous scan, the block scans: it frees idle list
// slots, then walks keys 0 .. keys_in_use-1 and moves each listed key through
// idle, pressed, hold and released, sending one event transfer per change
// (out_tuser = 1) and a closing summary transfer (out_tuser = 0, out_tlast = 1)
// whose any_activity bit tells whether a slot changed. The slot list lives in
// a ten-entry RAM with a registered read, so a scan sweeps it in passes: a
// clear pass, a search pass plus an update step per scanned key, and a
// summary pass; then the summary is loaded and handed over. The result side
// can stall a scan at the event and summary steps.
// No input transfer is taken while a scan runs; the pending summary sits in
// the output register, so the next tick is taken while it waits.
module key_list_debounce_hold_tracker_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input ticks.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] key_levels
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [3:0] key_index, [5:4] new_state,
                                  // [6] any_activity, [7] zero
  output logic        out_tuser,  // [0] is_event
  output logic        out_tlast,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SLOTS = klt_pkg::LIST_SLOTS;
  localparam int AW    = klt_pkg::SLOT_AW;
  localparam int TW    = klt_pkg::TICK_W;

  // Configuration registers.
  logic [15:0] debounce_r;
  logic [15:0] hold_r;
  logic [4:0]  keys_r;

  // Tick counters.
  logic [TW-1:0] since_scan_r;
  logic [TW-1:0] since_press_r;
  logic [TW-1:0] scan_inc;
  logic [TW-1:0] press_inc;

  klt_pkg::fsm_t state_r, state_nxt;

  // Sweep control: cnt_r is the next address to read, pend_r flags that the
  // RAM output holds entry paddr_r.
  logic [AW:0]   cnt_r;
  logic          pend_r;
  logic [AW-1:0] paddr_r;
  logic          issue;
  logic          sweep_done;

  logic [15:0]   levels_r;
  logic [4:0]    key_r;
  logic [4:0]    key_count;
  logic          pressed;

  // Search results for the current key.
  logic          found_r;
  logic [AW-1:0] found_idx_r;
  logic [1:0]    found_st_r;
  logic          free_r;
  logic [AW-1:0] free_idx_r;
  logic          act_r;

  // Slot RAM and its per-entry valid bits (an unwritten entry reads as zero).
  logic [SLOTS-1:0]     valid_r;
  logic                 rd_ok_r;
  logic [klt_pkg::SLOT_W-1:0] ram_rdata;
  klt_pkg::slot_t       rd_slot;
  klt_pkg::slot_t       wr_slot;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;

  // Advance decision.
  logic          do_slot;
  logic [AW-1:0] adv_idx;
  logic [1:0]    cur_st;
  logic [1:0]    new_st;
  logic          moved;
  logic          out_free;
  logic          adv_fire;

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_user_r;
  logic       out_last_r;
  logic       out_load;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == klt_pkg::FSM_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  assign scan_inc  = (since_scan_r  == klt_pkg::TICK_MAX) ? since_scan_r  : since_scan_r + 1'b1;
  assign press_inc = (since_press_r == klt_pkg::TICK_MAX) ? since_press_r : since_press_r + 1'b1;

  assign key_count  = (keys_r > 5'(klt_pkg::MAX_KEYS)) ? 5'(klt_pkg::MAX_KEYS) : keys_r;
  assign pressed    = !levels_r[key_r[3:0]];
  assign issue      = (state_r == klt_pkg::FSM_CLEAR || state_r == klt_pkg::FSM_SEARCH ||
                       state_r == klt_pkg::FSM_SUMMARY) && (cnt_r < (AW+1)'(SLOTS));
  assign sweep_done = (cnt_r == (AW+1)'(SLOTS)) && !pend_r;
  assign rd_slot    = rd_ok_r ? klt_pkg::slot_t'(ram_rdata) : '0;

  // The output register takes an event or the summary only when it is free.
  assign out_load = (state_r == klt_pkg::FSM_ADVANCE && do_slot && moved && adv_fire) ||
                    (state_r == klt_pkg::FSM_REPORT && out_free);

  // Advance step: either the listed slot or a freshly taken free one.
  always_comb begin
    do_slot = found_r || (pressed && free_r);
    adv_idx = found_r ? found_idx_r : free_idx_r;
    cur_st  = found_r ? found_st_r : klt_pkg::ST_IDLE;
    new_st  = cur_st;
    moved   = 1'b0;
    case (cur_st)
      klt_pkg::ST_IDLE: begin
        if (pressed) begin
          new_st = klt_pkg::ST_PRESSED;
          moved  = 1'b1;
        end
      end
      klt_pkg::ST_PRESSED: begin
        if (since_press_r > {1'b0, hold_r}) begin
          new_st = klt_pkg::ST_HOLD;
          moved  = 1'b1;
        end else if (!pressed) begin
          new_st = klt_pkg::ST_RELEASED;
          moved  = 1'b1;
        end
      end
      klt_pkg::ST_HOLD: begin
        if (!pressed) begin
          new_st = klt_pkg::ST_RELEASED;
          moved  = 1'b1;
        end
      end
      default: begin
        new_st = klt_pkg::ST_IDLE;
        moved  = 1'b1;
      end
    endcase
    adv_fire = !moved || out_free;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      klt_pkg::FSM_IDLE: begin
        if (in_tvalid && scan_inc > {1'b0, debounce_r}) begin
          state_nxt = klt_pkg::FSM_CLEAR;
        end
      end
      klt_pkg::FSM_CLEAR: begin
        if (sweep_done) begin
          state_nxt = (key_count == 5'd0) ? klt_pkg::FSM_SUMMARY : klt_pkg::FSM_SEARCH;
        end
      end
      klt_pkg::FSM_SEARCH: begin
        if (sweep_done) begin
          state_nxt = klt_pkg::FSM_ADVANCE;
        end
      end
      klt_pkg::FSM_ADVANCE: begin
        if (!do_slot || adv_fire) begin
          state_nxt = (key_r + 5'd1 >= key_count) ? klt_pkg::FSM_SUMMARY
                                                  : klt_pkg::FSM_SEARCH;
        end
      end
      klt_pkg::FSM_SUMMARY: begin
        if (sweep_done) begin
          state_nxt = klt_pkg::FSM_REPORT;
        end
      end
      klt_pkg::FSM_REPORT: begin
        if (out_free) begin
          state_nxt = klt_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = klt_pkg::FSM_IDLE;
    endcase
  end

  // RAM write port: clear pass and slot update.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = paddr_r;
    wr_slot   = rd_slot;
    case (state_r)
      klt_pkg::FSM_CLEAR: begin
        if (pend_r && rd_slot.kstate == klt_pkg::ST_IDLE) begin
          ram_we          = 1'b1;
          wr_slot.used    = 1'b0;
          wr_slot.changed = 1'b0;
        end
      end
      klt_pkg::FSM_ADVANCE: begin
        ram_waddr       = adv_idx;
        wr_slot.used    = 1'b1;
        wr_slot.key     = key_r[3:0];
        wr_slot.kstate  = new_st;
        wr_slot.changed = moved;
        ram_we          = do_slot && adv_fire;
      end
      default: ram_we = 1'b0;
    endcase
  end

  klt_ram #(
    .WIDTH(klt_pkg::SLOT_W),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_slot),
    .re   (issue),
    .raddr(cnt_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= klt_pkg::FSM_IDLE;
      debounce_r    <= 16'd10;
      hold_r        <= 16'd500;
      keys_r        <= 5'd16;
      since_scan_r  <= '0;
      since_press_r <= '0;
      valid_r       <= '0;
      rd_ok_r       <= 1'b0;
      cnt_r         <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      key_r         <= '0;
      found_r       <= 1'b0;
      free_r        <= 1'b0;
      act_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          klt_pkg::REG_DEBOUNCE: debounce_r <= cfg_data;
          klt_pkg::REG_HOLD:     hold_r     <= cfg_data;
          klt_pkg::REG_KEYS:     keys_r     <= cfg_data[4:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end

      // Sweep pipeline.
      pend_r <= issue;
      if (issue) begin
        rd_ok_r <= valid_r[cnt_r[AW-1:0]];
        paddr_r <= cnt_r[AW-1:0];
        cnt_r   <= cnt_r + 1'b1;
      end

      case (state_r)
        klt_pkg::FSM_IDLE: begin
          if (in_tvalid) begin
            since_press_r <= press_inc;
            levels_r      <= in_tdata;
            key_r         <= '0;
            cnt_r         <= '0;
            found_r       <= 1'b0;
            free_r        <= 1'b0;
            act_r         <= 1'b0;
            since_scan_r  <= (scan_inc > {1'b0, debounce_r}) ? '0 : scan_inc;
          end
        end
        klt_pkg::FSM_CLEAR: begin
          if (sweep_done) begin
            cnt_r <= '0;
          end
        end
        klt_pkg::FSM_SEARCH: begin
          if (pend_r) begin
            if (rd_slot.used && rd_slot.key == key_r[3:0] && !found_r) begin
              found_r     <= 1'b1;
              found_idx_r <= paddr_r;
              found_st_r  <= rd_slot.kstate;
            end
            if (!rd_slot.used && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= paddr_r;
            end
          end
        end
        klt_pkg::FSM_ADVANCE: begin
          if (!do_slot || adv_fire) begin
            key_r   <= key_r + 5'd1;
            cnt_r   <= '0;
            found_r <= 1'b0;
            free_r  <= 1'b0;
            if (do_slot && moved) begin
              out_user_r  <= 1'b1;
              out_last_r  <= 1'b0;
              out_data_r  <= {2'b00, new_st, key_r[3:0]};
              if (cur_st == klt_pkg::ST_IDLE) begin
                since_press_r <= '0;
              end
            end
          end
        end
        klt_pkg::FSM_SUMMARY: begin
          if (pend_r && rd_slot.changed) begin
            act_r <= 1'b1;
          end
        end
        klt_pkg::FSM_REPORT: begin
          if (out_free) begin
            out_user_r  <= 1'b0;
            out_last_r  <= 1'b1;
            out_data_r  <= {1'b0, act_r, 6'd0};
          end
        end
        default: ;
      endcase
    end
  end

  // An event never carries tlast and the summary always does.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != out_tlast))
    else $error("event and summary markers disagree");

  // The slot RAM is written only by the clear pass and the update step.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == klt_pkg::FSM_CLEAR || state_r == klt_pkg::FSM_ADVANCE))
    else $error("slot RAM written outside a scan");

  // A new result is loaded only when the output register is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("pending result overwritten");

endmodule
